FILE: rtl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

  // channel and register geometry
  localparam int CH_W       = 8;
  localparam int EN_W       = 5;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

  // enable bit positions
  localparam int EN_INVERT = 0;
  localparam int EN_THRESH = 1;
  localparam int EN_DIAG   = 2;
  localparam int EN_FRAME  = 3;
  localparam int EN_CIRCLE = 4;

  // reset values and fixed constants
  localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [CH_W-1:0]      THRESH_LVL = 8'd100;
  localparam logic [CH_W-1:0]      CH_MAX     = 8'd255;
  localparam int                   SQRT_SHIFT = 14;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            row_end;
    logic            frame_end;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/pfc_front.sv
`default_nettype none

module pfc_front import pfc_pkg::*; #(
  parameter int MAX_DIM = 4096,
  parameter int DIM_W   = 13,
  parameter int CNT_W   = 12,
  parameter int ENT_W   = 50
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pixel_t                in_pixel_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output logic [ENT_W-1:0]           q_data_o,
  output logic [EN_W-1:0]            en_o,
  output logic [DIM_W-1:0]           width_o,
  output logic [DIM_W-1:0]           height_o
);

  logic [EN_W-1:0]      en_q;
  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [CNT_W-1:0]     col_q, col_d, row_q, row_d;
  logic [31:0]          w_ext, h_ext, w_eff, h_eff;
  logic [DIM_W:0]       col_nx, row_nx;
  logic                 rend, fend;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= '0;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLES: en_q <= cfg_data_i[EN_W-1:0];
        CFG_WIDTH:   width_q <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to the supported range
  always_comb begin
    w_ext = 32'(width_q);
    h_ext = 32'(height_q);
    if (w_ext < 32'd2) w_eff = 32'd2;
    else if (w_ext > 32'(MAX_DIM)) w_eff = 32'(MAX_DIM);
    else w_eff = w_ext;
    if (h_ext < 32'd2) h_eff = 32'd2;
    else if (h_ext > 32'(MAX_DIM)) h_eff = 32'(MAX_DIM);
    else h_eff = h_ext;
  end

  assign en_o     = en_q;
  assign width_o  = w_eff[DIM_W-1:0];
  assign height_o = h_eff[DIM_W-1:0];

  // position tracking and row / frame end flags
  always_comb begin
    col_nx = (DIM_W+1)'(col_q) + (DIM_W+1)'(1);
    row_nx = (DIM_W+1)'(row_q) + (DIM_W+1)'(1);
    rend   = col_nx >= (DIM_W+1)'(width_o);
    fend   = rend && (row_nx >= (DIM_W+1)'(height_o));
    col_d  = col_q;
    row_d  = row_q;
    if (rend) begin
      col_d = '0;
      row_d = fend ? '0 : row_nx[CNT_W-1:0];
    end else begin
      col_d = col_nx[CNT_W-1:0];
    end
  end

  assign q_push_o   = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_data_o   = {in_pixel_i, col_q, row_q, rend, fend};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (q_push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pfc_queue.sv
`default_nettype none

module pfc_queue #(
  parameter int ENT_W = 50
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [ENT_W-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [ENT_W-1:0]      data_o,
  output logic                  empty_o
);

  logic [ENT_W-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("fill count did not follow transfer");

endmodule

`default_nettype wire

FILE: rtl/pfc_div.sv
`default_nettype none

module pfc_div #(
  parameter int DEN_W  = 26,
  parameter int LOW_W  = 16,
  parameter int STEP_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [DEN_W-1:0]  rem_i,
  input  wire logic [LOW_W-1:0]  low_i,
  input  wire logic [STEP_W-1:0] steps_i,
  output logic                   done_o,
  output logic [LOW_W-1:0]       quo_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DEN_W-1:0]  den_q, rem_q, rem_d;
  logic [LOW_W-1:0]  sh_q, quo_q;
  logic [DEN_W:0]    r2;
  logic              ge;

  // one restoring step: bring down a bit, subtract if it fits
  always_comb begin
    r2    = {rem_q, sh_q[LOW_W-1]};
    ge    = r2 >= {1'b0, den_q};
    rem_d = ge ? DEN_W'(r2 - {1'b0, den_q}) : r2[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= rem_i;
      sh_q  <= low_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[LOW_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/pfc_sqrt.sv
`default_nettype none

module pfc_sqrt #(
  parameter int OUT_W = 22
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*OUT_W-1:0] rad_i,
  output logic                    done_o,
  output logic [OUT_W-1:0]        root_o
);

  localparam int IN_W  = 2 * OUT_W;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IN_W-1:0]  rad_q;
  logic [OUT_W+1:0] rem_q, rem_d;
  logic [OUT_W-1:0] root_q;
  logic [OUT_W+3:0] rem2, trial;
  logic             ge;

  // one result bit per cycle, two radicand bits brought down
  always_comb begin
    rem2  = {rem_q, rad_q[IN_W-1:IN_W-2]};
    trial = (OUT_W+4)'({root_q, 2'b01});
    ge    = rem2 >= trial;
    rem_d = ge ? (OUT_W+2)'(rem2 - trial) : rem2[OUT_W+1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(OUT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= {root_q[OUT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/pfc_back.sv
`default_nettype none

module pfc_back import pfc_pkg::*; #(
  parameter int MAX_DIM        = 4096,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int ENT_W          = 50
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [EN_W-1:0]  en_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] width_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] height_i,
  input  wire logic             q_empty_i,
  input  wire logic [ENT_W-1:0] q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output result_t               out_result_o
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int GF      = GAIN_FRAC_BITS;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int DX_W    = DIM_W + 1;
  localparam int SS_W    = 2 * DX_W + 1 + SQRT_SHIFT;
  localparam int SQ_W    = (SS_W + 1) / 2;
  localparam int DEN_W   = (AREA_W > DIM_W + 8) ? AREA_W : DIM_W + 8;
  localparam int LOW_W   = GF;
  localparam int STEP_W  = $clog2(LOW_W + 1);
  localparam int MA_0    = (AREA_W > CH_W + DIM_W) ? AREA_W : CH_W + DIM_W;
  localparam int MA_W    = (MA_0 > GF + 1) ? MA_0 : GF + 1;
  localparam int MB_W    = (DX_W > CH_W) ? DX_W : CH_W;
  localparam int P_W     = MA_W + MB_W;
  localparam int C_0     = (SQ_W + 5 > DIM_W + 10) ? SQ_W + 5 : DIM_W + 10;
  localparam int CMP_W   = C_0 + 1;

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_DG_A  = 22'h000002,
    S_DG_B  = 22'h000004,
    S_DG_C  = 22'h000008,
    S_DG_D  = 22'h000010,
    S_DG_M  = 22'h000020,
    S_DG_DS = 22'h000040,
    S_DG_DW = 22'h000080,
    S_FR_A  = 22'h000100,
    S_FR_M1 = 22'h000200,
    S_FR_M2 = 22'h000400,
    S_FR_DS = 22'h000800,
    S_FR_DW = 22'h001000,
    S_CI_A  = 22'h002000,
    S_CI_B  = 22'h004000,
    S_CI_S  = 22'h008000,
    S_CI_SW = 22'h010000,
    S_CI_G  = 22'h020000,
    S_CI_GW = 22'h040000,
    S_CI_M  = 22'h080000,
    S_CI_W  = 22'h100000,
    S_OUT   = 22'h200000
  } state_e;

  state_e state_q, state_d;
  state_e nx_pre, nx_dg, nx_fr;

  // working item
  logic [CH_W-1:0]  ch_q [3];
  logic [1:0]       idx_q;
  logic [CNT_W-1:0] col_q, row_q;
  logic             rend_q, fend_q;
  logic [AREA_W-1:0] area_q, wt_q;
  logic [P_W-1:0]   prod_q, t1_q;
  logic [SQ_W-1:0]  dq_q;
  logic [GF:0]      g_q;
  logic             out_valid_q;
  result_t          out_q;

  // unpacked queue entry
  pixel_t           e_pix;
  logic [CNT_W-1:0] e_col, e_row;
  logic             e_rend, e_fend;
  logic [CH_W-1:0]  pre [3];

  // shared multiplier
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;

  // geometry
  logic [DIM_W-1:0]  mi, mj, row_e, col_e, di, dj, wi, wj, l_min;
  logic [DX_W-1:0]   dx, dy, w_x, h_x, col2, row2;
  logic [AREA_W-1:0] hc, wr, dd, wt_d;
  logic [SS_W-1:0]   ss;
  logic [CMP_W-1:0]  dq_c, l_c, l256, num, dq12, dq24, dq8, l512, l768;
  logic              ring0, ring1, ring2, ring_any;
  logic [1:0]        ring_sel;
  logic              num_ge;
  logic              out_free;

  // divider and square root hookup
  logic              div_start, div_done;
  logic [DEN_W-1:0]  div_den, div_rem;
  logic [LOW_W-1:0]  div_low, div_quo;
  logic [STEP_W-1:0] div_steps;
  logic              sq_start, sq_done;
  logic [SQ_W-1:0]   sq_root;

  assign {e_pix, e_col, e_row, e_rend, e_fend} = q_data_i;

  // invert and threshold on the way in
  always_comb begin
    pre[0] = e_pix.in_red;
    pre[1] = e_pix.in_green;
    pre[2] = e_pix.in_blue;
    for (int i = 0; i < 3; i++) begin
      if (en_i[EN_INVERT]) pre[i] = CH_MAX - pre[i];
      if (en_i[EN_THRESH] && (pre[i] < THRESH_LVL)) pre[i] = '0;
    end
  end

  // which stage follows which
  always_comb begin
    nx_fr  = en_i[EN_CIRCLE] ? S_CI_A : S_OUT;
    nx_dg  = en_i[EN_FRAME] ? S_FR_A : nx_fr;
    nx_pre = en_i[EN_DIAG] ? S_DG_A : nx_dg;
  end

  // position dependent terms
  always_comb begin
    row_e = DIM_W'(row_q);
    col_e = DIM_W'(col_q);
    mi    = height_i >> 1;
    mj    = width_i >> 1;
    di    = (mi > row_e) ? mi - row_e : row_e - mi;
    dj    = (mj > col_e) ? mj - col_e : col_e - mj;
    wi    = (di < mi) ? mi - di : '0;
    wj    = (dj < mj) ? mj - dj : '0;
    w_x   = DX_W'(width_i);
    h_x   = DX_W'(height_i);
    col2  = DX_W'({col_q, 1'b0});
    row2  = DX_W'({row_q, 1'b0});
    dx    = (w_x > col2) ? w_x - col2 : col2 - w_x;
    dy    = (h_x > row2) ? h_x - row2 : row2 - h_x;
    hc    = t1_q[AREA_W-1:0];
    wr    = prod_q[AREA_W-1:0];
    dd    = (hc > wr) ? hc - wr : wr - hc;
    wt_d  = (dd < area_q) ? area_q - dd : '0;
    ss    = (SS_W'(t1_q[2*DX_W-1:0]) + SS_W'(prod_q[2*DX_W-1:0])) << SQRT_SHIFT;
  end

  // ring selection and gain numerator
  always_comb begin
    l_min = (width_i < height_i) ? width_i : height_i;
    dq_c  = CMP_W'(dq_q);
    l_c   = CMP_W'(l_min);
    l256  = l_c << 8;
    l512  = l_c << 9;
    l768  = l256 + l512;
    dq8   = dq_c << 3;
    dq12  = (dq_c << 3) + (dq_c << 2);
    dq24  = dq12 << 1;
    ring0 = dq12 < l256;
    ring1 = dq_c < (l_c << 6);
    ring2 = dq_c < (l_c << 7);
    ring_any = ring0 || ring1 || ring2;
    if (ring0) begin
      ring_sel = 2'd0;
      num = (l256 > dq24) ? l256 - dq24 : dq24 - l256;
    end else if (ring1) begin
      ring_sel = 2'd1;
      num = (l512 > dq12) ? l512 - dq12 : dq12 - l512;
    end else begin
      ring_sel = 2'd2;
      num = (l768 > dq8) ? l768 - dq8 : dq8 - l768;
    end
    num_ge = num >= l256;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DG_A:  begin mul_a = MA_W'(width_i);      mul_b = MB_W'(height_i); end
      S_DG_B:  begin mul_a = MA_W'(col_q);        mul_b = MB_W'(height_i); end
      S_DG_C:  begin mul_a = MA_W'(row_q);        mul_b = MB_W'(width_i);  end
      S_DG_M:  begin mul_a = MA_W'(wt_q);         mul_b = MB_W'(ch_q[idx_q]); end
      S_FR_A:  begin mul_a = MA_W'(mi);           mul_b = MB_W'(mj);       end
      S_FR_M1: begin mul_a = MA_W'(wi);           mul_b = MB_W'(ch_q[idx_q]); end
      S_FR_M2: begin
        mul_a = MA_W'(prod_q[CH_W+DIM_W-1:0]);
        mul_b = MB_W'(wj);
      end
      S_CI_A:  begin mul_a = MA_W'(dx);           mul_b = MB_W'(dx);       end
      S_CI_B:  begin mul_a = MA_W'(dy);           mul_b = MB_W'(dy);       end
      S_CI_M:  begin mul_a = MA_W'(g_q);          mul_b = MB_W'(ch_q[idx_q]); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(mul_a) * P_W'(mul_b);
  end

  // divider and root requests
  always_comb begin
    div_start = 1'b0;
    div_den   = '0;
    div_rem   = '0;
    div_low   = '0;
    div_steps = '0;
    unique case (state_q) inside
      S_DG_DS, S_FR_DS: begin
        div_start = 1'b1;
        div_den   = DEN_W'(area_q);
        div_rem   = DEN_W'(prod_q[P_W-1:CH_W]);
        div_low   = LOW_W'(prod_q[CH_W-1:0]) << (LOW_W - CH_W);
        div_steps = STEP_W'(CH_W);
      end
      S_CI_G: begin
        div_start = ring_any && !num_ge;
        div_den   = DEN_W'(l256);
        div_rem   = DEN_W'(num);
        div_steps = STEP_W'(GF);
      end
      default: ;
    endcase
  end

  assign sq_start = state_q == S_CI_S;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (!q_empty_i) state_d = nx_pre;
      S_DG_A:  state_d = S_DG_B;
      S_DG_B:  state_d = S_DG_C;
      S_DG_C:  state_d = S_DG_D;
      S_DG_D:  state_d = S_DG_M;
      S_DG_M:  state_d = S_DG_DS;
      S_DG_DS: state_d = S_DG_DW;
      S_DG_DW: if (div_done) state_d = (idx_q == 2'd2) ? nx_dg : S_DG_M;
      S_FR_A:  state_d = S_FR_M1;
      S_FR_M1: state_d = S_FR_M2;
      S_FR_M2: state_d = S_FR_DS;
      S_FR_DS: state_d = S_FR_DW;
      S_FR_DW: if (div_done) state_d = (idx_q == 2'd2) ? nx_fr : S_FR_M1;
      S_CI_A:  state_d = S_CI_B;
      S_CI_B:  state_d = S_CI_S;
      S_CI_S:  state_d = S_CI_SW;
      S_CI_SW: if (sq_done) state_d = S_CI_G;
      S_CI_G: begin
        if (!ring_any) state_d = S_OUT;
        else if (num_ge) state_d = S_CI_M;
        else state_d = S_CI_GW;
      end
      S_CI_GW: if (div_done) state_d = S_CI_M;
      S_CI_M:  state_d = S_CI_W;
      S_CI_W:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      S_IDLE: begin
        ch_q   <= pre;
        col_q  <= e_col;
        row_q  <= e_row;
        rend_q <= e_rend;
        fend_q <= e_fend;
        idx_q  <= 2'd0;
      end
      S_DG_B:  area_q <= prod_q[AREA_W-1:0];
      S_DG_C:  t1_q <= prod_q;
      S_DG_D:  wt_q <= wt_d;
      S_DG_DW, S_FR_DW: begin
        if (div_done) begin
          ch_q[idx_q] <= div_quo[CH_W-1:0];
          idx_q       <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
      end
      S_FR_M1: if (idx_q == 2'd0) area_q <= prod_q[AREA_W-1:0];
      S_CI_B:  t1_q <= prod_q;
      S_CI_SW: if (sq_done) dq_q <= sq_root;
      S_CI_G: begin
        idx_q <= ring_sel;
        g_q   <= (GF+1)'(1) << GF;
      end
      S_CI_GW: if (div_done) g_q <= (GF+1)'(div_quo);
      S_CI_W:  ch_q[idx_q] <= prod_q[GF+CH_W-1:GF];
      S_OUT: begin
        if (out_free) out_q <= '{ch_q[0], ch_q[1], ch_q[2], rend_q, fend_q};
      end
      default: ;
    endcase
  end

  pfc_div #(
    .DEN_W  (DEN_W),
    .LOW_W  (LOW_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (div_den),
    .rem_i   (div_rem),
    .low_i   (div_low),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  pfc_sqrt #(
    .OUT_W (SQ_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ((2*SQ_W)'(ss)),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/pixel_filter_chain.sv
// the back-end sequencer with its shared multiplier, bit-serial divider and
//   bit-serial square root holds one pixel at a time
// a two-entry queue lets the front take pixels while the back end works
// reset: asynchronous, active low; counters clear, enables clear, size returns to 640x480
`default_nettype none

module pixel_filter_chain import pfc_pkg::*; #(
  parameter int MAX_DIM        = 4096,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pixel_t                in_pixel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output result_t                    out_result_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int ENT_W = 3 * CH_W + 2 * CNT_W + 2;

  logic             q_full, q_push, q_pop, q_empty;
  logic [ENT_W-1:0] q_wdata, q_rdata;
  logic [EN_W-1:0]  en;
  logic [DIM_W-1:0] width, height;

  pfc_front #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W),
    .CNT_W   (CNT_W),
    .ENT_W   (ENT_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pixel_i (in_pixel_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .en_o       (en),
    .width_o    (width),
    .height_o   (height)
  );

  pfc_queue #(
    .ENT_W (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  pfc_back #(
    .MAX_DIM        (MAX_DIM),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ENT_W          (ENT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .width_i      (width),
    .height_i     (height),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pfc_pkg::*;

  localparam int MAX_DIM_TB  = 4096;
  localparam int GAIN_FRAC   = 16;
  localparam int RAND_ITEMS  = 1300;
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  pixel_t                in_pixel_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  result_t               out_result_o;

  pixel_filter_chain i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_pixel_i   (in_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

  // shadow of the block's registers and position counters
  logic [EN_W-1:0]      shadow_en;
  logic [CFG_DIM_W-1:0] shadow_width;
  logic [CFG_DIM_W-1:0] shadow_height;
  longint unsigned      pos_col;
  longint unsigned      pos_row;

  result_t expected_pixels[$];
  int      error_count;
  int      cycle_count;
  bit      stall_quiet;
  bit      hold_rx;
  int      hold_cycles;

  typedef struct {
    pixel_t  pix;
    bit      has_exp;
    result_t exp;
  } stim_row_t;

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic longint unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM_TB) return MAX_DIM_TB;
    return v;
  endfunction

  function automatic longint unsigned absdiff(longint unsigned a, longint unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // filter one pixel at the current position and advance the counters
  function automatic result_t filter_pixel(pixel_t p);
    longint unsigned ch[3];
    longint unsigned w, h, col, row, area, d, wt, mi, mj, wi, wj;
    longint unsigned l, dx, dy, dq, den, num, g, one;
    int sel;
    bit rend, fend;
    result_t r;
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    col = pos_col;
    row = pos_row;
    ch[0] = p.in_red;
    ch[1] = p.in_green;
    ch[2] = p.in_blue;
    if (shadow_en[EN_INVERT]) for (int i = 0; i < 3; i++) ch[i] = CH_MAX - ch[i];
    if (shadow_en[EN_THRESH])
      for (int i = 0; i < 3; i++) if (ch[i] < THRESH_LVL) ch[i] = 0;
    if (shadow_en[EN_DIAG]) begin
      area = w * h;
      d = absdiff(h * col, w * row);
      wt = d < area ? area - d : 0;
      for (int i = 0; i < 3; i++) ch[i] = ch[i] * wt / area;
    end
    if (shadow_en[EN_FRAME]) begin
      mi = h / 2;
      mj = w / 2;
      wi = absdiff(mi, row) < mi ? mi - absdiff(mi, row) : 0;
      wj = absdiff(mj, col) < mj ? mj - absdiff(mj, col) : 0;
      for (int i = 0; i < 3; i++) ch[i] = ch[i] * wi * wj / (mi * mj);
    end
    if (shadow_en[EN_CIRCLE]) begin
      l = w < h ? w : h;
      dx = absdiff(w, 2 * col);
      dy = absdiff(h, 2 * row);
      dq = isqrt((dx * dx + dy * dy) << SQRT_SHIFT);
      den = 256 * l;
      sel = -1;
      num = 0;
      if (12 * dq < 256 * l) begin
        sel = 0;
        num = absdiff(256 * l, 24 * dq);
      end else if (dq < 64 * l) begin
        sel = 1;
        num = absdiff(512 * l, 12 * dq);
      end else if (dq < 128 * l) begin
        sel = 2;
        num = absdiff(768 * l, 8 * dq);
      end
      if (sel >= 0) begin
        one = 64'd1 << GAIN_FRAC;
        g = (num << GAIN_FRAC) / den;
        if (g > one) g = one;
        ch[sel] = (ch[sel] * g) >> GAIN_FRAC;
      end
    end
    rend = col + 1 >= w;
    fend = rend && (row + 1 >= h);
    if (rend) begin
      pos_col = 0;
      pos_row = fend ? 0 : row + 1;
    end else begin
      pos_col = col + 1;
    end
    r.out_red   = ch[0][7:0];
    r.out_green = ch[1][7:0];
    r.out_blue  = ch[2][7:0];
    r.row_end   = rend;
    r.frame_end = fend;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // result checking
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        e = expected_pixels.pop_front();
        if (out_result_o.out_red != e.out_red)
          report_mismatch("out_red", int'(out_result_o.out_red), int'(e.out_red));
        if (out_result_o.out_green != e.out_green)
          report_mismatch("out_green", int'(out_result_o.out_green), int'(e.out_green));
        if (out_result_o.out_blue != e.out_blue)
          report_mismatch("out_blue", int'(out_result_o.out_blue), int'(e.out_blue));
        if (out_result_o.row_end != e.row_end)
          report_mismatch("row_end", int'(out_result_o.row_end), int'(e.row_end));
        if (out_result_o.frame_end != e.frame_end)
          report_mismatch("frame_end", int'(out_result_o.frame_end), int'(e.frame_end));
      end
    end
  end

  // receiver stall bursts, with long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        hold_cycles = 0;
        out_stall_i <= 1'b1;
        while (hold_cycles < 300) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        out_stall_i <= 1'b0;
        hold_rx = 1'b0;
      end else if (!stall_quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENABLES) shadow_en = val[EN_W-1:0];
    else if (idx == CFG_WIDTH) shadow_width = val;
    else if (idx == CFG_HEIGHT) shadow_height = val;
  endtask

  // wait for the pipeline to drain; a size change does not reset the
  // counters, so they are kept as they are
  task automatic drain;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send_pixel(pixel_t p, bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= p;
    expected_pixels.insert(expected_pixels.size(), filter_pixel(p));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_idle;
    in_valid_i <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.in_red   = 8'($urandom);
    p.in_green = 8'($urandom);
    p.in_blue  = 8'($urandom);
    if ($urandom_range(0, 7) == 0) p.in_red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 7) == 0) p.in_green = 8'($urandom_range(95, 104));
    return p;
  endfunction

  stim_row_t directed_rows[$];

  task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit chk,
                         logic [7:0] er, logic [7:0] eg, logic [7:0] eb, bit re, bit fe);
    stim_row_t s;
    s.pix = '{in_red: r, in_green: g, in_blue: b};
    s.has_exp = chk;
    s.exp = '{out_red: er, out_green: eg, out_blue: eb, row_end: re, frame_end: fe};
    directed_rows.insert(directed_rows.size(), s);
  endtask

  task automatic run_rows;
    result_t typed;
    foreach (directed_rows[k]) begin
      typed = directed_rows[k].exp;
      send_pixel(directed_rows[k].pix, 1'b0);
      // typed values must agree with the predictor's own
      if (directed_rows[k].has_exp && expected_pixels[$] != typed)
        report_mismatch("directed row", k, k);
    end
    send_idle();
    directed_rows.delete();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    stall_quiet = 1'b0;
    hold_rx     = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ENABLES;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_pixel_i  = '0;
    shadow_en     = '0;
    shadow_width  = RST_WIDTH;
    shadow_height = RST_HEIGHT;
    pos_col = 0;
    pos_row = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: pass-through at 640x480
    add_row(8'd0, 8'd255, 8'd128, 1'b1, 8'd0, 8'd255, 8'd128, 1'b0, 1'b0);
    add_row(8'd255, 8'd0, 8'd1, 1'b1, 8'd255, 8'd0, 8'd1, 1'b0, 1'b0);
    run_rows();
    drain();

    // tiny 2x2 frame, invert and threshold: row and frame ends typed in
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_HEIGHT, 13'd1);
    write_reg(CFG_ENABLES, 13'd3);
    // the column is already past the new width, so the current row ends at once
    add_row(8'd0, 8'd255, 8'd156, 1'b1, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
    add_row(8'd155, 8'd156, 8'd100, 1'b1, 8'd100, 8'd0, 8'd155, 1'b0, 1'b0);
    add_row(8'd0, 8'd0, 8'd0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    add_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    add_row(8'd200, 8'd50, 8'd99, 1'b1, 8'd0, 8'd205, 8'd156, 1'b1, 1'b0);
    run_rows();
    drain();

    // each weighting stage alone, on small frames
    for (int m = 2; m <= 4; m++) begin
      write_reg(CFG_ENABLES, CFG_DATA_W'(1 << m));
      write_reg(CFG_WIDTH, 13'd5);
      write_reg(CFG_HEIGHT, 13'd4);
      for (int k = 0; k < 6; k++)
        add_row(8'd255, 8'd255, 8'd255, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      run_rows();
      drain();
    end

    // largest and out-of-range size, shrink mid-frame
    write_reg(CFG_ENABLES, 13'd31);
    write_reg(CFG_WIDTH, 13'd8191);
    write_reg(CFG_HEIGHT, 13'd4096);
    for (int k = 0; k < 5; k++) add_row(8'd255, 8'd128, 8'd1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    run_rows();
    drain();
    write_reg(CFG_WIDTH, 13'd3);
    write_reg(CFG_HEIGHT, 13'd2);
    for (int k = 0; k < 4; k++)
      add_row(8'd200, 8'd200, 8'd200, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    run_rows();
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(CFG_ENABLES, CFG_DATA_W'($urandom_range(0, 31)));
      write_reg(CFG_WIDTH,
                CFG_DATA_W'(ph % 5 == 4 ? $urandom : $urandom_range(2, 12)));
      write_reg(CFG_HEIGHT,
                CFG_DATA_W'(ph % 5 == 4 ? $urandom_range(4090, 8191) : $urandom_range(0, 10)));
      if (ph == 12) stall_quiet = 1'b1;
      if (ph == 3) hold_rx = 1'b1;
      for (int k = 0; k < RAND_ITEMS / 13; k++) begin
        send_pixel(rand_pixel(), ph != 12);
        // sender waits for the block to run dry once
        if (ph == 6 && k == 40) begin
          send_idle();
          while (expected_pixels.size() != 0) @(posedge clk_i);
        end
      end
      send_idle();
      drain();
    end
    write_reg(CFG_ENABLES, 13'd31);
    write_reg(CFG_WIDTH, 13'd2);
    write_reg(CFG_HEIGHT, 13'd4096);
    for (int k = 0; k < 8; k++) send_pixel(rand_pixel(), 1'b0);
    send_idle();
    drain();

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
